// File: rtl/midpoint_circle_arc_generator_macros.svh
// Assertion macros for the midpoint circle arc generator.
// Used by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef MIDPOINT_CIRCLE_ARC_GENERATOR_MACROS_SVH
`define MIDPOINT_CIRCLE_ARC_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCAG_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
		else $error("mcag assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MCAG_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
		else $error("mcag assertion failed");

`endif

// File: rtl/mcag_pkg.sv
// Shared types and constants of the midpoint circle arc generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mcag_pkg;

	localparam int CFG_W   = 12;  // centre coordinate register width
	localparam int RAD_W   = 11;  // radius field width
	localparam int STATE_W = 12;  // stored x and y width
	localparam int DEC_W   = 14;  // decision value width, two's complement
	localparam int OFS_W   = 14;  // signed offset width handed to the mirror logic
	localparam int ADDR_W  = 3;   // APB address width, registers at 0 and 4

	// Action codes
	localparam logic ACT_START = 1'b0;

	// Register indexes
	localparam logic REG_CENTER_ROW = 1'b0;
	localparam logic REG_CENTER_COL = 1'b1;

	// One input beat
	typedef struct packed {
		logic             action;
		logic [RAD_W-1:0] radius;
		logic             half;
	} mcag_item_t;

	// One generated point set before mirroring
	typedef struct packed {
		logic                    live;  // a point set was produced
		logic                    done;  // this step ended the octant
		logic                    half;  // 1 right half mirrors, 0 left
		logic signed [OFS_W-1:0] px;
		logic signed [OFS_W-1:0] py;
	} mcag_point_t;

endpackage

// File: rtl/mcag_apb_regs.sv
// APB configuration registers: centre row and centre column.
// Depends on mcag_pkg.
`timescale 1ns / 1ps

module mcag_apb_regs import mcag_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic [CFG_W-1:0]  center_row,
	output logic [CFG_W-1:0]  center_col
);

	logic             wr_en;
	logic             reg_idx;
	logic [CFG_W-1:0] rd_val;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1];

	// Write the addressed register on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_row <= '0;
			center_col <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CENTER_ROW: center_row <= pwdata[CFG_W-1:0];
				REG_CENTER_COL: center_col <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		case (reg_idx)
			REG_CENTER_ROW: rd_val = center_row;
			REG_CENTER_COL: rd_val = center_col;
			default:        rd_val = '0;
		endcase
		prdata = {{(32-CFG_W){1'b0}}, rd_val};
	end

endmodule

// File: rtl/mcag_arc_state.sv
// Arc state and decision update of the midpoint circle generator.
// Depends on mcag_pkg; produces at most one unmirrored point set per advanced beat.
`timescale 1ns / 1ps

module mcag_arc_state import mcag_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  mcag_item_t  item,
	output mcag_point_t pt
);

	logic [STATE_W-1:0]      step_x_q, step_y_q;
	logic signed [DEC_W-1:0] dec_q;
	logic                    half_q, finished_q;

	logic signed [OFS_W-1:0] x_ext, y_ext, x_n, y_n;
	logic signed [DEC_W-1:0] dec_n;
	logic [STATE_W-1:0]      step_x_n, step_y_n;
	logic                    half_n, finished_n, done_n;

	assign x_ext = $signed({{(OFS_W-STATE_W){1'b0}}, step_x_q});
	assign y_ext = $signed({{(OFS_W-STATE_W){1'b0}}, step_y_q});

	// Compute the next point and state for the held beat
	always_comb begin
		step_x_n   = step_x_q;
		step_y_n   = step_y_q;
		dec_n      = dec_q;
		half_n     = half_q;
		finished_n = finished_q;
		x_n        = x_ext;
		y_n        = y_ext;
		done_n     = 1'b0;
		pt         = '0;
		if (item.action == ACT_START) begin
			// Load a new arc at the top of the octant
			x_n        = '0;
			y_n        = $signed({{(OFS_W-RAD_W){1'b0}}, item.radius});
			dec_n      = DEC_W'(1) - $signed({{(DEC_W-RAD_W){1'b0}}, item.radius});
			step_x_n   = '0;
			step_y_n   = {{(STATE_W-RAD_W){1'b0}}, item.radius};
			half_n     = item.half;
			finished_n = 1'b0;
			pt.live    = 1'b1;
			pt.half    = item.half;
			pt.px      = x_n;
			pt.py      = y_n;
		end else if (!finished_q) begin
			// Advance x; step y down when the midpoint lies outside
			if (dec_q[DEC_W-1]) begin
				dec_n = dec_q + (x_ext <<< 1) + DEC_W'(3);
				y_n   = y_ext;
			end else begin
				dec_n = dec_q + ((x_ext - y_ext) <<< 1) + DEC_W'(5);
				y_n   = y_ext - OFS_W'(1);
			end
			x_n        = x_ext + OFS_W'(1);
			done_n     = (y_n < x_n);
			step_x_n   = x_n[STATE_W-1:0];
			step_y_n   = y_n[OFS_W-1] ? '0 : y_n[STATE_W-1:0];
			finished_n = done_n;
			pt.live    = 1'b1;
			pt.done    = done_n;
			pt.half    = half_q;
			pt.px      = x_n;
			pt.py      = y_n;
		end
	end

	// Commit the state when the beat moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_x_q   <= '0;
			step_y_q   <= '0;
			dec_q      <= '0;
			half_q     <= 1'b0;
			finished_q <= 1'b1;
		end else if (adv) begin
			step_x_q   <= step_x_n;
			step_y_q   <= step_y_n;
			dec_q      <= dec_n;
			half_q     <= half_n;
			finished_q <= finished_n;
		end
	end

endmodule

// File: rtl/mcag_point_map.sv
// Mirror logic: places four points around the centre and clips them to the grid.
// Depends on mcag_pkg; purely combinational.
`timescale 1ns / 1ps

module mcag_point_map import mcag_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  mcag_point_t           pt,
	input  logic [CFG_W-1:0]      center_row,
	input  logic [CFG_W-1:0]      center_col,
	output logic [COORD_BITS-1:0] rows [4],
	output logic [COORD_BITS-1:0] cols [4],
	output logic [3:0]            out_of_range,
	output logic                  points_new,
	output logic                  arc_done
);

	localparam int PW = (COORD_BITS + 2 > OFS_W + 1) ? COORD_BITS + 2 : OFS_W + 1;
	localparam logic signed [PW-1:0] LIM = PW'((64'd1 << COORD_BITS) - 64'd1);

	logic signed [PW-1:0] cr, cc, xs, ys;
	logic signed [PW-1:0] row_v [4];
	logic signed [PW-1:0] col_v [4];

	function automatic logic [COORD_BITS-1:0] clip(input logic signed [PW-1:0] v);
		if (v[PW-1])
			clip = '0;
		else if (v > LIM)
			clip = '1;
		else
			clip = v[COORD_BITS-1:0];
	endfunction

	function automatic logic outside(input logic signed [PW-1:0] v);
		outside = v[PW-1] || (v > LIM);
	endfunction

	assign cr = $signed({{(PW-CFG_W){1'b0}}, center_row});
	assign cc = $signed({{(PW-CFG_W){1'b0}}, center_col});
	assign xs = PW'(pt.px);
	assign ys = PW'(pt.py);

	// Form the four mirrored positions
	always_comb begin
		row_v[0] = cr + ys;  col_v[0] = cc + xs;
		row_v[1] = cr + xs;  col_v[1] = cc + ys;
		if (pt.half) begin
			row_v[2] = cr - xs;  col_v[2] = cc + ys;
			row_v[3] = cr - ys;  col_v[3] = cc + xs;
		end else begin
			row_v[2] = cr + xs;  col_v[2] = cc - ys;
			row_v[3] = cr + ys;  col_v[3] = cc - xs;
		end
	end

	// Clip each point and flag it; drop everything when no point was made
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if (pt.live) begin
				rows[k]         = clip(row_v[k]);
				cols[k]         = clip(col_v[k]);
				out_of_range[k] = outside(row_v[k]) | outside(col_v[k]);
			end else begin
				rows[k]         = '0;
				cols[k]         = '0;
				out_of_range[k] = 1'b0;
			end
		end
		points_new = pt.live;
		arc_done   = pt.live & pt.done;
	end

endmodule

// File: rtl/midpoint_circle_arc_generator.sv
// Top level of the midpoint circle arc generator: input stage, output register.
// Depends on mcag_pkg, mcag_apb_regs, mcag_arc_state, mcag_point_map and the macros header.
//
// Usage:
//   Input channel (item_valid / item_stall): one beat carries action, arc_radius and
//   half_select. action = start loads a radius and half; action = step advances x.
//   Output channel (result_valid / result_stall): one beat per input beat, carrying
//   four mirrored points, out_of_range flags, points_new and arc_done.
//   APB port: center_row at address 0, center_col at address 4; write while idle.
// Flow: an accepted beat is registered in the input stage, then processed into the output
//   register, from which it can be taken.
// Throughput: one beat per cycle unless stalled. The arc state registers update in the same
//   edge that moves the input stage into the output register, so the next beat sees them.
// Reset: arst_n clears both stages, the centre registers and the arc state; no arc
//   is active afterwards, so steps return all-zero result beats until a start.
// Stall: while result_stall holds a full output register, the input stage holds its
//   beat and item_stall rises once the input stage is occupied.
`timescale 1ns / 1ps
`include "midpoint_circle_arc_generator_macros.svh"

module midpoint_circle_arc_generator import mcag_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// Input channel
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  action,
	input  logic [RAD_W-1:0]      arc_radius,
	input  logic                  half_select,
	// Output channel
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [COORD_BITS-1:0] row_a,
	output logic [COORD_BITS-1:0] col_a,
	output logic [COORD_BITS-1:0] row_b,
	output logic [COORD_BITS-1:0] col_b,
	output logic [COORD_BITS-1:0] row_c,
	output logic [COORD_BITS-1:0] col_c,
	output logic [COORD_BITS-1:0] row_d,
	output logic [COORD_BITS-1:0] col_d,
	output logic [3:0]            out_of_range,
	output logic                  points_new,
	output logic                  arc_done
);

	logic             valid_s1;
	mcag_item_t       item_s1;
	logic             out_free, adv;
	logic [CFG_W-1:0] center_row, center_col;
	mcag_point_t      pt;

	logic [COORD_BITS-1:0] rows_c [4];
	logic [COORD_BITS-1:0] cols_c [4];
	logic [3:0]            oor_c;
	logic                  new_c, done_c;

	logic [COORD_BITS-1:0] rows_q [4];
	logic [COORD_BITS-1:0] cols_q [4];
	logic [3:0]            oor_q;
	logic                  new_q, done_q, result_valid_q;

	// Configuration registers
	mcag_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.center_row (center_row),
		.center_col (center_col)
	);

	// Handshake: the output register frees when empty or being taken
	assign out_free   = ~result_valid_q | ~result_stall;
	assign adv        = valid_s1 & out_free;
	assign item_stall = valid_s1 & ~out_free;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1.action <= action;
			item_s1.radius <= arc_radius;
			item_s1.half   <= half_select;
		end
	end

	// Arc state and step arithmetic
	mcag_arc_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.pt     (pt)
	);

	// Mirror and clip
	mcag_point_map #(
		.COORD_BITS (COORD_BITS)
	) u_map (
		.pt           (pt),
		.center_row   (center_row),
		.center_col   (center_col),
		.rows         (rows_c),
		.cols         (cols_c),
		.out_of_range (oor_c),
		.points_new   (new_c),
		.arc_done     (done_c)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rows_q <= rows_c;
			cols_q <= cols_c;
			oor_q  <= oor_c;
			new_q  <= new_c;
			done_q <= done_c;
		end
	end

	assign result_valid = result_valid_q;
	assign row_a        = rows_q[0];
	assign col_a        = cols_q[0];
	assign row_b        = rows_q[1];
	assign col_b        = cols_q[1];
	assign row_c        = rows_q[2];
	assign col_c        = cols_q[2];
	assign row_d        = rows_q[3];
	assign col_d        = cols_q[3];
	assign out_of_range = oor_q;
	assign points_new   = new_q;
	assign arc_done     = done_q;

	// Checks on the datapath and stage control
	`MCAG_ASSERT_IMPLIES(a_done_has_points, clk, arst_n, result_valid_q && done_q, new_q)
	`MCAG_ASSERT_IMPLIES(a_range_has_points, clk, arst_n, result_valid_q && (oor_q != 4'd0), new_q)
	`MCAG_ASSERT_IMPLIES(a_stall_only_when_full, clk, arst_n, item_stall, result_valid_q && result_stall)
	`MCAG_ASSERT_NEXT(a_stage_drains, clk, arst_n, adv, result_valid_q)

endmodule
